// ----- hdl/imu_datagram_framer_crc32_check_core_assert.svh -----
`ifndef IMU_DATAGRAM_FRAMER_CRC32_CHECK_CORE_ASSERT_SVH
`define IMU_DATAGRAM_FRAMER_CRC32_CHECK_CORE_ASSERT_SVH

// Check that cons holds in the same cycle as ante
`define IMU_DFC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante
`define IMU_DFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/imu_dfc_pkg.sv -----
package imu_dfc_pkg;

   localparam int unsigned POS_WIDTH = 6;

   localparam logic [31:0] CRC_POLY   = 32'h04C11DB7;
   localparam logic [31:0] CRC_SEED   = 32'hFFFFFFFF;
   localparam logic [7:0]  SYNC_RESET = 8'hA5;
   localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

   // One finished record check
   typedef struct packed {
      logic        crc_bad;
      logic [31:0] computed_crc;
      logic [31:0] received_crc;
      logic [15:0] bad_record_count;
   } result_type;

   // Feed one byte through the CRC, MSB first
   function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {data, 24'h000000};
      for (int i = 0; i < 8; i++) begin
         if (c[31]) begin
            c = {c[30:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[30:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ----- hdl/imu_datagram_framer_crc32_check_core.sv -----
// Framed record CRC-32 checker. Received bytes enter on req_ one per transaction;
// bytes are dropped until one equals the sync byte (csr_write_data, reset A5h), which
// opens a record of RECORD_BYTES bytes. The CRC-32 (poly 04C11DB7, MSB first, seed
// all ones, no final xor) runs over all but the last four bytes, is padded with two
// zero bytes and is compared with the last four bytes taken big-endian; a length for
// which RECORD_BYTES - 2 is not a multiple of four flags every record bad. Each record
// yields one rsp_ transaction with the flag, both CRCs and a saturating 16-bit bad
// count. Throughput is one byte per clock: the byte-wide CRC update sits between the
// input register and the CRC register, and the pad bytes are folded in while the
// trailer arrives. A record's closing byte passes from the input register to the result
// register. A stalled result stops the input only when the byte waiting in the input
// register closes a record. A sync byte change takes effect at the next hunt.
`include "imu_datagram_framer_crc32_check_core_assert.svh"

module imu_datagram_framer_crc32_check_core #(
   parameter int unsigned RECORD_BYTES = 38
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_crc_bad,
   output logic [31:0] rsp_computed_crc,
   output logic [31:0] rsp_received_crc,
   output logic [15:0] rsp_bad_record_count
);

   logic [7:0]              sync_ff;
   logic                    in_valid_ff, in_valid_in;
   logic [7:0]              in_byte_ff, in_byte_in;
   logic                    accept;
   logic                    advance;
   logic                    at_last;
   logic                    emit;
   logic                    out_free;
   imu_dfc_pkg::result_type result;
   imu_dfc_pkg::result_type rsp_result;

   // Hold the sync byte register
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff <= imu_dfc_pkg::SYNC_RESET;
      end else if (csr_write_enable) begin
         sync_ff <= csr_write_data;
      end
   end

   // Advance the held byte unless it closes a record and the result slot is busy
   assign advance   = in_valid_ff && (!at_last || out_free);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   // Input register
   always_comb begin
      in_byte_in = in_byte_ff;
      if (accept) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_rx_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   imu_dfc_framer #(
      .RECORD_BYTES (RECORD_BYTES)
   ) u_framer (
      .clock     (clock),
      .reset     (reset),
      .sync_byte (sync_ff),
      .step      (advance),
      .rx_byte   (in_byte_ff),
      .at_last   (at_last),
      .emit      (emit),
      .result    (result)
   );

   imu_dfc_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (emit),
      .result     (result),
      .rsp_stall  (rsp_stall),
      .free       (out_free),
      .rsp_valid  (rsp_valid),
      .rsp_result (rsp_result)
   );

   assign rsp_crc_bad          = rsp_result.crc_bad;
   assign rsp_computed_crc     = rsp_result.computed_crc;
   assign rsp_received_crc     = rsp_result.received_crc;
   assign rsp_bad_record_count = rsp_result.bad_record_count;

   `IMU_DFC_ASSERT_SAME(a_emit_held, clock, reset, emit, in_valid_ff,
      "result without a held byte")
   `IMU_DFC_ASSERT_NEXT(a_in_hold, clock, reset, in_valid_ff && !advance,
      in_valid_ff && $stable(in_byte_ff), "held byte lost while stalled")
   `IMU_DFC_ASSERT_SAME(a_stall_cause, clock, reset, req_stall,
      at_last && rsp_valid && rsp_stall, "input stalled without a busy result slot")

endmodule

// ----- hdl/imu_dfc_framer.sv -----
`include "imu_datagram_framer_crc32_check_core_assert.svh"

module imu_dfc_framer #(
   parameter int unsigned RECORD_BYTES = 38
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [7:0]               sync_byte,
   input  logic                     step,
   input  logic [7:0]               rx_byte,
   output logic                     at_last,
   output logic                     emit,
   output imu_dfc_pkg::result_type  result
);

   localparam int unsigned PW = imu_dfc_pkg::POS_WIDTH;
   localparam logic [PW-1:0] LAST_POS    = PW'(RECORD_BYTES - 1);
   localparam logic [PW-1:0] TRAILER_POS = PW'(RECORD_BYTES - 4);
   localparam logic [PW-1:0] PAD_END_POS = PW'(RECORD_BYTES - 2);
   localparam bit LENGTH_OK = (((RECORD_BYTES - 2) % 4) == 0);

   logic [PW-1:0] pos_ff, pos_in;
   logic [31:0]   crc_ff, crc_in;
   logic [31:0]   trailer_ff, trailer_in;
   logic [15:0]   count_ff, count_in;
   logic [31:0]   received;
   logic          bad;

   assign at_last  = (pos_ff == LAST_POS);
   assign emit     = step && at_last;
   assign received = {trailer_ff[23:0], rx_byte};
   // the CRC already holds the two zero pad bytes by the last byte
   assign bad      = !LENGTH_OK || (crc_ff != received);

   // Advance the record position, CRC and trailer
   always_comb begin
      pos_in     = pos_ff;
      crc_in     = crc_ff;
      trailer_in = trailer_ff;
      count_in   = count_ff;
      if (step) begin
         if (pos_ff == '0 && rx_byte != sync_byte) begin
            pos_in = pos_ff;
         end else if (pos_ff < TRAILER_POS) begin
            crc_in = imu_dfc_pkg::crc_feed(crc_ff, rx_byte);
            pos_in = pos_ff + PW'(1);
         end else if (pos_ff < LAST_POS) begin
            // pad the CRC with one zero byte on each of the first two trailer bytes
            if (pos_ff < PAD_END_POS) begin
               crc_in = imu_dfc_pkg::crc_feed(crc_ff, 8'h00);
            end
            trailer_in = {trailer_ff[23:0], rx_byte};
            pos_in     = pos_ff + PW'(1);
         end else begin
            if (bad && count_ff != imu_dfc_pkg::COUNT_MAX) begin
               count_in = count_ff + 16'd1;
            end
            pos_in     = '0;
            crc_in     = imu_dfc_pkg::CRC_SEED;
            trailer_in = '0;
         end
      end
   end

   // Build the result of the finishing byte
   always_comb begin
      result.crc_bad          = bad;
      result.computed_crc     = crc_ff;
      result.received_crc     = received;
      result.bad_record_count = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         crc_ff     <= imu_dfc_pkg::CRC_SEED;
         trailer_ff <= '0;
         count_ff   <= '0;
      end else begin
         pos_ff     <= pos_in;
         crc_ff     <= crc_in;
         trailer_ff <= trailer_in;
         count_ff   <= count_in;
      end
   end

   `IMU_DFC_ASSERT_SAME(a_pos_range, clock, reset, 1'b1, pos_ff <= LAST_POS, "position past record end")
   `IMU_DFC_ASSERT_NEXT(a_count_hold, clock, reset, !emit, $stable(count_ff), "bad count moved without a result")
   `IMU_DFC_ASSERT_NEXT(a_count_step, clock, reset, emit && bad && count_ff != imu_dfc_pkg::COUNT_MAX, count_ff == $past(count_ff) + 16'd1, "bad count did not advance")

endmodule

// ----- hdl/imu_dfc_out_reg.sv -----
`include "imu_datagram_framer_crc32_check_core_assert.svh"

module imu_dfc_out_reg (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  imu_dfc_pkg::result_type  result,
   input  logic                     rsp_stall,
   output logic                     free,
   output logic                     rsp_valid,
   output imu_dfc_pkg::result_type  rsp_result
);

   logic                    valid_ff, valid_in;
   imu_dfc_pkg::result_type data_ff, data_in;

   // Slot can take a new result when empty or being drained this cycle
   assign free = !valid_ff || !rsp_stall;

   // Load a new result or drop the delivered one
   always_comb begin
      data_in = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = data_ff;

   `IMU_DFC_ASSERT_SAME(a_load_free, clock, reset, load, free, "result loaded over a waiting transaction")
   `IMU_DFC_ASSERT_NEXT(a_load_valid, clock, reset, load, valid_ff, "loaded result not presented")
   `IMU_DFC_ASSERT_NEXT(a_hold_data, clock, reset, valid_ff && rsp_stall && !load, $stable(data_ff), "stalled result changed")

endmodule
